// File: hw/rtl/rscp_pkg.sv
// Shared types and constants of the slot pool compactor.
`timescale 1ns / 1ps
package rscp_pkg;

	// Table geometry.
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	// Command codes on the op field.
	typedef enum logic [2:0] {
		OP_ALLOC   = 3'd0,
		OP_ADDREF  = 3'd1,
		OP_FREE    = 3'd2,
		OP_COMPACT = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_EMPTY    = 3'd1,
		STS_MISMATCH = 3'd2,
		STS_FULL     = 3'd3,
		STS_BAD_SLOT = 3'd4,
		STS_CLEAN    = 3'd5,
		STS_NONE     = 3'd6
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_UPDATE,
		S_CVERT,
		S_CIDX,
		S_RESP
	} state_t;

	// Operations of the shared arithmetic unit.
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_INC,
		ALU_DEC
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        zero;
	} alu_rsp_t;

	// One result as handed from the sequencer to the output register.
	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [3:0]  slot;
		logic [31:0] base_vertex;
		logic [31:0] first_index;
		logic [15:0] ref_count;
		logic        has_geometry;
		logic        last;
	} res_t;

endpackage

// File: hw/rtl/rscp_alu.sv
// Shared adder unit: running-sum add, saturating increment and floored decrement.
`timescale 1ns / 1ps
module rscp_alu (
	input  rscp_pkg::alu_req_t req,
	output rscp_pkg::alu_rsp_t rsp
);

	logic [31:0] sum;

	// One adder serves all three operations.
	always_comb begin
		case (req.op)
			rscp_pkg::ALU_ADD: sum = req.a + req.b;
			rscp_pkg::ALU_INC: sum = (req.a[15:0] == 16'hFFFF) ? req.a : req.a + 32'd1;
			rscp_pkg::ALU_DEC: sum = (req.a[15:0] <= 16'd1) ? 32'd0 : req.a - 32'd1;
			default:           sum = req.a;
		endcase
	end

	assign rsp.sum  = sum;
	assign rsp.zero = (sum == 32'd0);

endmodule

// File: hw/rtl/rscp_core.sv
// Sequencer and slot table of the slot pool compactor.
`timescale 1ns / 1ps
module rscp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          op,
	input  logic [3:0]          slot,
	input  logic [23:0]         vertex_count,
	input  logic [23:0]         index_count,
	input  logic [9:0]          stride_bytes,
	output rscp_pkg::alu_req_t  alu_req,
	input  rscp_pkg::alu_rsp_t  alu_rsp,
	output rscp_pkg::res_t      res,
	input  logic                res_ready
);

	// Control state.
	rscp_pkg::state_t                 state_q, state_d;
	logic [rscp_pkg::CNT_W-1:0]       idx_q;
	logic [rscp_pkg::CNT_W-1:0]       used_q;
	logic [9:0]                       stride_q;
	logic                             dirty_q;
	logic [rscp_pkg::NUM_SLOTS-1:0]   active_q;

	// Captured command.
	rscp_pkg::op_t op_q;
	logic [3:0]    slot_q;
	logic [23:0]   vc_q;
	logic [23:0]   ic_q;
	logic [9:0]    st_q;

	// Slot table, all read and written at the walk index.
	logic [15:0] refs_q  [rscp_pkg::NUM_SLOTS];
	logic [23:0] vert_q  [rscp_pkg::NUM_SLOTS];
	logic [23:0] ind_q   [rscp_pkg::NUM_SLOTS];
	logic [31:0] base_q  [rscp_pkg::NUM_SLOTS];
	logic [31:0] first_q [rscp_pkg::NUM_SLOTS];

	// Running offsets and the pending result.
	logic [31:0]         vcur_q;
	logic [31:0]         icur_q;
	rscp_pkg::status_t   res_status_q;
	logic [3:0]          res_slot_q;
	logic                res_rd_q;
	logic                last_q;

	logic [rscp_pkg::SLOT_W-1:0]    idx_lo;
	logic [rscp_pkg::SLOT_W-1:0]    slot_idx;
	logic                           slot_ok;
	logic                           empty_mesh;
	logic [9:0]                     eff_stride;
	logic                           mismatch;
	logic                           scan_end;
	logic                           full;
	logic                           cur_active;
	logic                           do_alloc;
	logic [rscp_pkg::NUM_SLOTS-1:0] above;
	logic                           last_c;

	// Decode of the command and the current walk position.
	assign idx_lo     = idx_q[rscp_pkg::SLOT_W-1:0];
	assign slot_idx   = slot_q[rscp_pkg::SLOT_W-1:0];
	assign slot_ok    = (rscp_pkg::CNT_W'(slot_q) < used_q) && active_q[slot_idx];
	assign empty_mesh = (vc_q == 24'd0) || (ic_q == 24'd0);
	assign eff_stride = (stride_q == 10'd0) ? st_q : stride_q;
	assign mismatch   = (st_q != eff_stride);
	assign scan_end   = (idx_q == used_q);
	assign full       = (used_q == rscp_pkg::CNT_W'(rscp_pkg::NUM_SLOTS));
	assign cur_active = active_q[idx_lo];
	assign do_alloc   = (state_q == rscp_pkg::S_SCAN) && (scan_end ? !full : !cur_active);
	assign above      = (active_q >> idx_lo) >> 1;
	assign last_c     = (above == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rscp_pkg::S_IDLE: begin
				if (in_valid) state_d = rscp_pkg::S_DISPATCH;
			end
			rscp_pkg::S_DISPATCH: begin
				case (op_q)
					rscp_pkg::OP_ALLOC: begin
						state_d = (empty_mesh || mismatch) ? rscp_pkg::S_RESP : rscp_pkg::S_SCAN;
					end
					rscp_pkg::OP_ADDREF, rscp_pkg::OP_FREE: begin
						state_d = slot_ok ? rscp_pkg::S_UPDATE : rscp_pkg::S_RESP;
					end
					rscp_pkg::OP_QUERY: begin
						state_d = rscp_pkg::S_RESP;
					end
					rscp_pkg::OP_COMPACT: begin
						state_d = (!dirty_q || active_q == '0) ? rscp_pkg::S_RESP
							: rscp_pkg::S_CVERT;
					end
					default: state_d = rscp_pkg::S_IDLE;
				endcase
			end
			rscp_pkg::S_SCAN: begin
				if (scan_end || !cur_active) state_d = rscp_pkg::S_RESP;
			end
			rscp_pkg::S_UPDATE: state_d = rscp_pkg::S_RESP;
			rscp_pkg::S_CVERT: begin
				if (cur_active) state_d = rscp_pkg::S_CIDX;
			end
			rscp_pkg::S_CIDX: state_d = rscp_pkg::S_RESP;
			rscp_pkg::S_RESP: begin
				if (res_ready) state_d = last_q ? rscp_pkg::S_IDLE : rscp_pkg::S_CVERT;
			end
			default: state_d = rscp_pkg::S_IDLE;
		endcase
	end

	// Outputs: handshake, shared unit operands and the result.
	always_comb begin
		in_ready          = (state_q == rscp_pkg::S_IDLE);
		alu_req.op        = rscp_pkg::ALU_ADD;
		alu_req.a         = 32'd0;
		alu_req.b         = 32'd0;
		res.valid         = (state_q == rscp_pkg::S_RESP);
		res.status        = res_status_q;
		res.slot          = res_slot_q;
		res.base_vertex   = res_rd_q ? base_q[idx_lo] : 32'd0;
		res.first_index   = res_rd_q ? first_q[idx_lo] : 32'd0;
		res.ref_count     = res_rd_q ? refs_q[idx_lo] : 16'd0;
		res.has_geometry  = (active_q != '0);
		res.last          = last_q;
		case (state_q)
			rscp_pkg::S_UPDATE: begin
				alu_req.op = (op_q == rscp_pkg::OP_ADDREF) ? rscp_pkg::ALU_INC : rscp_pkg::ALU_DEC;
				alu_req.a  = {16'd0, refs_q[idx_lo]};
			end
			rscp_pkg::S_CVERT: begin
				alu_req.a = vcur_q;
				alu_req.b = {8'd0, vert_q[idx_lo]};
			end
			rscp_pkg::S_CIDX: begin
				alu_req.a = icur_q;
				alu_req.b = {8'd0, ind_q[idx_lo]};
			end
			default: begin
				alu_req.op = rscp_pkg::ALU_ADD;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rscp_pkg::S_IDLE;
			idx_q    <= '0;
			used_q   <= '0;
			stride_q <= 10'd0;
			dirty_q  <= 1'b0;
			active_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rscp_pkg::S_DISPATCH: begin
					case (op_q)
						rscp_pkg::OP_ALLOC: begin
							if (!empty_mesh && stride_q == 10'd0) stride_q <= st_q;
							idx_q <= '0;
						end
						rscp_pkg::OP_ADDREF, rscp_pkg::OP_FREE, rscp_pkg::OP_QUERY: begin
							idx_q <= rscp_pkg::CNT_W'(slot_q);
						end
						rscp_pkg::OP_COMPACT: begin
							if (dirty_q) dirty_q <= 1'b0;
							idx_q <= '0;
						end
						default: idx_q <= idx_q;
					endcase
				end
				rscp_pkg::S_SCAN: begin
					if (do_alloc) begin
						active_q[idx_lo] <= 1'b1;
						dirty_q          <= 1'b1;
						if (scan_end) used_q <= used_q + rscp_pkg::CNT_W'(1);
					end else if (!scan_end) begin
						idx_q <= idx_q + rscp_pkg::CNT_W'(1);
					end
				end
				rscp_pkg::S_UPDATE: begin
					if (op_q == rscp_pkg::OP_FREE && alu_rsp.zero) begin
						active_q[idx_lo] <= 1'b0;
						dirty_q          <= 1'b1;
					end
				end
				rscp_pkg::S_CVERT: begin
					if (!cur_active) idx_q <= idx_q + rscp_pkg::CNT_W'(1);
				end
				rscp_pkg::S_RESP: begin
					if (res_ready && !last_q) idx_q <= idx_q + rscp_pkg::CNT_W'(1);
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// Command capture, table contents and the pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			rscp_pkg::S_IDLE: begin
				if (in_valid) begin
					op_q   <= rscp_pkg::op_t'(op);
					slot_q <= slot;
					vc_q   <= vertex_count;
					ic_q   <= index_count;
					st_q   <= stride_bytes;
				end
			end
			rscp_pkg::S_DISPATCH: begin
				last_q       <= 1'b1;
				res_rd_q     <= 1'b0;
				res_slot_q   <= 4'd0;
				res_status_q <= rscp_pkg::STS_OK;
				case (op_q)
					rscp_pkg::OP_ALLOC: begin
						if (empty_mesh) res_status_q <= rscp_pkg::STS_EMPTY;
						else if (mismatch) res_status_q <= rscp_pkg::STS_MISMATCH;
					end
					rscp_pkg::OP_ADDREF, rscp_pkg::OP_FREE, rscp_pkg::OP_QUERY: begin
						res_slot_q   <= slot_q;
						res_rd_q     <= slot_ok;
						res_status_q <= slot_ok ? rscp_pkg::STS_OK : rscp_pkg::STS_BAD_SLOT;
					end
					rscp_pkg::OP_COMPACT: begin
						vcur_q <= 32'd0;
						icur_q <= 32'd0;
						if (!dirty_q) res_status_q <= rscp_pkg::STS_CLEAN;
						else if (active_q == '0) res_status_q <= rscp_pkg::STS_NONE;
					end
					default: res_status_q <= rscp_pkg::STS_OK;
				endcase
			end
			rscp_pkg::S_SCAN: begin
				if (do_alloc) begin
					refs_q[idx_lo]  <= 16'd1;
					vert_q[idx_lo]  <= vc_q;
					ind_q[idx_lo]   <= ic_q;
					base_q[idx_lo]  <= 32'd0;
					first_q[idx_lo] <= 32'd0;
					res_status_q    <= rscp_pkg::STS_OK;
					res_slot_q      <= 4'(idx_lo);
					res_rd_q        <= 1'b1;
				end else if (scan_end) begin
					res_status_q <= rscp_pkg::STS_FULL;
				end
			end
			rscp_pkg::S_UPDATE: begin
				refs_q[idx_lo] <= alu_rsp.sum[15:0];
			end
			rscp_pkg::S_CVERT: begin
				if (cur_active) begin
					base_q[idx_lo] <= vcur_q;
					vcur_q         <= alu_rsp.sum;
				end
			end
			rscp_pkg::S_CIDX: begin
				first_q[idx_lo] <= icur_q;
				icur_q          <= alu_rsp.sum;
				res_status_q    <= rscp_pkg::STS_OK;
				res_slot_q      <= 4'(idx_lo);
				res_rd_q        <= 1'b1;
				last_q          <= last_c;
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

endmodule

// File: hw/rtl/refcounted_slot_pool_compactor_top.sv
// Top level of the reference-counted slot pool with compaction.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    op, slot, vertex_count, index_count, stride_bytes
//   result    out_valid / out_ready  status, slot_out, base_vertex, first_index,
//                                    ref_count, has_geometry, last
//
// One command is taken at a time; in_ready is high only while the sequencer idles.
// Allocate steps past each occupied slot in its search for a free one before it
// answers; addref and free update the count through the adder, while query and the
// refusals found at dispatch go straight to the result. Compact walks the slots in
// order and gives one result per active slot, as the running sums share one adder; a
// clean or empty pool gives a single refusal, and unknown commands give no result.
// A stalled result holds in the output register; the sequencer waits on it.
// Reset is asynchronous and leaves the pool empty, clean and with no stride.
`timescale 1ns / 1ps
module refcounted_slot_pool_compactor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [3:0]  slot,
	input  logic [23:0] vertex_count,
	input  logic [23:0] index_count,
	input  logic [9:0]  stride_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  slot_out,
	output logic [31:0] base_vertex,
	output logic [31:0] first_index,
	output logic [15:0] ref_count,
	output logic        has_geometry,
	output logic        last
);

	rscp_pkg::alu_req_t alu_req;
	rscp_pkg::alu_rsp_t alu_rsp;
	rscp_pkg::res_t     res;
	logic               res_ready;
	logic               load;
	logic               out_valid_q;
	rscp_pkg::res_t     out_q;

	rscp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.slot         (slot),
		.vertex_count (vertex_count),
		.index_count  (index_count),
		.stride_bytes (stride_bytes),
		.alu_req      (alu_req),
		.alu_rsp      (alu_rsp),
		.res          (res),
		.res_ready    (res_ready)
	);

	rscp_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// The output register takes a new result when empty or being drained.
	assign res_ready = !out_valid_q || out_ready;
	assign load      = res.valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign status       = 3'(out_q.status);
	assign slot_out     = out_q.slot;
	assign base_vertex  = out_q.base_vertex;
	assign first_index  = out_q.first_index;
	assign ref_count    = out_q.ref_count;
	assign has_geometry = out_q.has_geometry;
	assign last         = out_q.last;

endmodule

// File: hw/rtl/rscp_checker.sv
// Port-level checker of the slot pool compactor and its bind to the top level.
`timescale 1ns / 1ps
module rscp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [3:0]  slot_out,
	input logic [31:0] base_vertex,
	input logic [31:0] first_index,
	input logic [15:0] ref_count,
	input logic        has_geometry,
	input logic        last
);

	// A stalled result keeps its payload; has_geometry is not checked here.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_out)
			&& $stable(base_vertex) && $stable(first_index) && $stable(ref_count)
			&& $stable(last))
		else $error("result changed while stalled");

	// Only compaction gives several results, so any refusal ends its run.
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rscp_pkg::STS_OK |-> last)
		else $error("refusal is not the final result");

	// Refusals that name no slot carry zero offsets and count.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rscp_pkg::STS_EMPTY || status == rscp_pkg::STS_MISMATCH
			|| status == rscp_pkg::STS_FULL || status == rscp_pkg::STS_CLEAN
			|| status == rscp_pkg::STS_NONE)
		|-> slot_out == 4'd0 && base_vertex == 32'd0 && first_index == 32'd0
			&& ref_count == 16'd0)
		else $error("refusal carries slot data");

	// A live slot reported with a nonzero count means the pool holds geometry.
	a_live_geo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rscp_pkg::STS_OK && ref_count != 16'd0 |-> has_geometry)
		else $error("live slot reported without geometry");

	// A command transfer takes the block out of its idle state, so ready drops after it.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a command transfer");

endmodule

bind refcounted_slot_pool_compactor_top rscp_checker u_rscp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.slot_out     (slot_out),
	.base_vertex  (base_vertex),
	.first_index  (first_index),
	.ref_count    (ref_count),
	.has_geometry (has_geometry),
	.last         (last)
);

// File: tb/sv/slot_pool_checker.sv
// Checker that mirrors the slot pool and compares every result transfer.
`timescale 1ns / 1ps
module slot_pool_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  op,
	input  logic [3:0]  slot,
	input  logic [23:0] vertex_count,
	input  logic [23:0] index_count,
	input  logic [9:0]  stride_bytes,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic [3:0]  slot_out,
	input  logic [31:0] base_vertex,
	input  logic [31:0] first_index,
	input  logic [15:0] ref_count,
	input  logic        has_geometry,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	import rscp_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot;
		logic [31:0] base_vertex;
		logic [31:0] first_index;
		logic [15:0] ref_count;
		logic        has_geometry;
		logic        last;
	} pool_result_t;

	// Mirror of the slot table.
	bit              slot_live[NUM_SLOTS];
	bit [15:0]       slot_refs_m[NUM_SLOTS];
	bit [23:0]       slot_verts[NUM_SLOTS];
	bit [23:0]       slot_idxs[NUM_SLOTS];
	bit [31:0]       slot_base[NUM_SLOTS];
	bit [31:0]       slot_first[NUM_SLOTS];
	int              slots_in_use;
	bit [9:0]        adopted_stride;
	bit              needs_pack;

	pool_result_t    expected_results[$];
	int              faults;
	int              results_seen;

	// True while any live slot holds indices.
	function automatic logic pool_has_geometry();
		logic any;
		any = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (i < slots_in_use && slot_live[i] && slot_idxs[i] != '0)
				any = 1'b1;
		return any;
	endfunction

	task automatic note_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endtask

	// Apply one accepted command to the mirror and queue the results it causes.
	task automatic predict_pool_command(input logic [2:0] cmd, input logic [3:0] idx,
			input logic [23:0] vc, input logic [23:0] ic, input logic [9:0] st);
		pool_result_t r;
		int           pick;
		int           active_cnt;
		int           emitted;
		logic [31:0]  vsum;
		logic [31:0]  isum;
		logic         single;
		logic         live;
		live = (int'(idx) < slots_in_use) && slot_live[idx];
		r = '0;
		r.last = 1'b1;
		single = 1'b1;
		case (cmd)
			OP_ALLOC: begin
				if (vc == '0 || ic == '0) begin
					r.status = STS_EMPTY;
				end else begin
					// The first nonempty mesh fixes the stride, even if it is then refused.
					if (adopted_stride == '0)
						adopted_stride = st;
					pick = -1;
					for (int i = 0; i < NUM_SLOTS; i++)
						if (pick < 0 && i < slots_in_use && !slot_live[i])
							pick = i;
					if (st != adopted_stride) begin
						r.status = STS_MISMATCH;
					end else if (pick < 0 && slots_in_use == NUM_SLOTS) begin
						r.status = STS_FULL;
					end else begin
						if (pick < 0) begin
							pick = slots_in_use;
							slots_in_use++;
						end
						slot_live[pick] = 1'b1;
						slot_refs_m[pick] = 16'd1;
						slot_verts[pick] = vc;
						slot_idxs[pick] = ic;
						slot_base[pick] = '0;
						slot_first[pick] = '0;
						needs_pack = 1'b1;
						r.status = STS_OK;
						r.slot = 4'(pick);
						r.ref_count = 16'd1;
					end
				end
			end
			OP_ADDREF, OP_FREE, OP_QUERY: begin
				r.slot = idx;
				if (!live) begin
					r.status = STS_BAD_SLOT;
				end else begin
					if (cmd == OP_ADDREF) begin
						if (slot_refs_m[idx] != 16'hFFFF)
							slot_refs_m[idx] = slot_refs_m[idx] + 16'd1;
					end else if (cmd == OP_FREE) begin
						if (slot_refs_m[idx] <= 16'd1) begin
							slot_refs_m[idx] = '0;
							slot_live[idx] = 1'b0;
							needs_pack = 1'b1;
						end else begin
							slot_refs_m[idx] = slot_refs_m[idx] - 16'd1;
						end
					end
					r.status = STS_OK;
					r.base_vertex = slot_base[idx];
					r.first_index = slot_first[idx];
					r.ref_count = slot_refs_m[idx];
				end
			end
			OP_COMPACT: begin
				if (!needs_pack) begin
					r.status = STS_CLEAN;
				end else begin
					// Running offsets over the live slots in ascending order.
					needs_pack = 1'b0;
					vsum = '0;
					isum = '0;
					active_cnt = 0;
					for (int i = 0; i < NUM_SLOTS; i++)
						if (i < slots_in_use && slot_live[i]) begin
							slot_base[i] = vsum;
							slot_first[i] = isum;
							vsum = vsum + slot_verts[i];
							isum = isum + slot_idxs[i];
							active_cnt++;
						end
					if (active_cnt == 0) begin
						r.status = STS_NONE;
					end else begin
						single = 1'b0;
						emitted = 0;
						for (int i = 0; i < NUM_SLOTS; i++)
							if (i < slots_in_use && slot_live[i]) begin
								emitted++;
								r.status = STS_OK;
								r.slot = 4'(i);
								r.base_vertex = slot_base[i];
								r.first_index = slot_first[i];
								r.ref_count = slot_refs_m[i];
								r.has_geometry = pool_has_geometry();
								r.last = (emitted == active_cnt);
								expected_results.push_back(r);
							end
					end
				end
			end
			default: begin
				// Reserved commands leave the pool alone and answer nothing.
				single = 1'b0;
			end
		endcase
		if (single) begin
			r.has_geometry = pool_has_geometry();
			expected_results.push_back(r);
		end
	endtask

	// Compare result transfers first, then predict from command transfers.
	always @(posedge clk or negedge arst_n) begin
		pool_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_live[i] = 1'b0;
				slot_refs_m[i] = '0;
				slot_verts[i] = '0;
				slot_idxs[i] = '0;
				slot_base[i] = '0;
				slot_first[i] = '0;
			end
			slots_in_use = 0;
			adopted_stride = '0;
			needs_pack = 1'b0;
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					note_fault($sformatf({"unexpected result at %0t: status %0d slot %0d",
						" base %0h first %0h refs %0d geom %b last %b"}, $time, status,
						slot_out, base_vertex, first_index, ref_count, has_geometry, last));
				end else begin
					want = expected_results.pop_front();
					results_seen++;
					if (status !== want.status || slot_out !== want.slot ||
							base_vertex !== want.base_vertex ||
							first_index !== want.first_index ||
							ref_count !== want.ref_count ||
							has_geometry !== want.has_geometry || last !== want.last)
						note_fault($sformatf({"result mismatch at %0t: expected status %0d",
							" slot %0d base %0h first %0h refs %0d geom %b last %b;",
							" got status %0d slot %0d base %0h first %0h refs %0d",
							" geom %b last %b"}, $time, want.status, want.slot,
							want.base_vertex, want.first_index, want.ref_count,
							want.has_geometry, want.last, status, slot_out, base_vertex,
							first_index, ref_count, has_geometry, last));
				end
			end
			if (in_valid && in_ready)
				predict_pool_command(op, slot, vertex_count, index_count, stride_bytes);
		end
		fail_count <= faults;
		pending <= expected_results.size();
		checked <= results_seen;
	end

endmodule

// File: tb/sv/testbench.sv
// Top of the slot pool testbench: clock, reset, command and result traffic, verdict.
`timescale 1ns / 1ps
module testbench;
	import rscp_pkg::*;

	localparam int           CYCLE_LIMIT = 3_000_000;
	localparam int           HOLD_CYCLES = 300;
	localparam int           RANDOM_CMDS = 45;
	localparam int           BURST_ADDREFS = 4;
	localparam int           DRAIN_CYCLES = 160;
	localparam logic [2:0]   OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0]   OP_RSVD_LAST = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  op = '0;
	logic [3:0]  slot = '0;
	logic [23:0] vertex_count = '0;
	logic [23:0] index_count = '0;
	logic [9:0]  stride_bytes = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [3:0]  slot_out;
	logic [31:0] base_vertex;
	logic [31:0] first_index;
	logic [15:0] ref_count;
	logic        has_geometry;
	logic        last;

	int          fail_count;
	int          pending_cnt;
	int          results_checked;
	int          cycle_count = 0;
	int          cmds_sent = 0;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	bit          rx_hold_req = 1'b0;
	bit          rx_hold_done = 1'b0;
	logic [9:0]  mesh_stride;

	refcounted_slot_pool_compactor_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .slot(slot), .vertex_count(vertex_count),
		.index_count(index_count), .stride_bytes(stride_bytes),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .slot_out(slot_out), .base_vertex(base_vertex),
		.first_index(first_index), .ref_count(ref_count),
		.has_geometry(has_geometry), .last(last)
	);

	slot_pool_checker pool_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .slot(slot), .vertex_count(vertex_count),
		.index_count(index_count), .stride_bytes(stride_bytes),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .slot_out(slot_out), .base_vertex(base_vertex),
		.first_index(first_index), .ref_count(ref_count),
		.has_geometry(has_geometry), .last(last),
		.fail_count(fail_count), .pending(pending_cnt), .checked(results_checked)
	);

	always #5 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending_cnt);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Mesh size, occasionally empty.
	function automatic logic [23:0] mesh_count();
		if ($urandom_range(0, 15) == 0)
			return '0;
		return 24'($urandom_range(1, 24'hFFFFFF));
	endfunction

	// Mostly the pool stride, sometimes a random one.
	function automatic logic [9:0] stride_pick();
		if ($urandom_range(0, 7) == 0)
			return 10'($urandom_range(1, 1023));
		return mesh_stride;
	endfunction

	// One command transfer. Valid stays high when the next command follows at once.
	task automatic issue(input logic [2:0] cmd, input logic [3:0] idx,
			input logic [23:0] vc, input logic [23:0] ic, input logic [9:0] st);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= cmd;
		slot <= idx;
		vertex_count <= vc;
		index_count <= ic;
		stride_bytes <= st;
		do @(posedge clk); while (!in_ready);
		if (cmd <= OP_QUERY)
			cmds_sent++;
	endtask

	task automatic place_mesh(input logic [23:0] vc, input logic [23:0] ic,
			input logic [9:0] st);
		issue(OP_ALLOC, 4'($urandom_range(0, 15)), vc, ic, st);
	endtask

	task automatic touch_slot(input logic [2:0] cmd, input logic [3:0] idx);
		issue(cmd, idx, 24'($urandom), 24'($urandom), 10'($urandom));
	endtask

	// Result side: random stalls per result, plus one long hold-off on request.
	initial begin : result_sink
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_idle_en ? $urandom_range(0, 6) : 0;
			if (rx_hold_req && !rx_hold_done) begin
				gap = HOLD_CYCLES;
				rx_hold_done = 1'b1;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Command side and verdict.
	initial begin
		int kind;
		int burst;
		int rand_start;
		mesh_stride = 10'($urandom_range(2, 1022));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty table refuses lookups and has nothing to pack.
		touch_slot(OP_QUERY, 4'd0);
		touch_slot(OP_COMPACT, 4'($urandom_range(0, 15)));
		// Empty meshes are refused before any stride is adopted.
		place_mesh(24'd0, 24'd5, 10'd1);
		place_mesh(24'hFFFFFF, 24'd0, 10'd1023);
		place_mesh(24'd0, 24'd0, mesh_stride);
		// The first real mesh fixes the stride; other strides are refused.
		place_mesh(24'hFFFFFF, 24'hFFFFFF, mesh_stride);
		place_mesh(24'd1, 24'd1, 10'd1);
		place_mesh(24'd1, 24'd1, 10'd1023);
		place_mesh(24'd1, 24'd1, mesh_stride);
		touch_slot(OP_ADDREF, 4'd1);
		touch_slot(OP_QUERY, 4'd1);
		// Release to zero, then touch inactive and never-used slots.
		touch_slot(OP_FREE, 4'd0);
		touch_slot(OP_QUERY, 4'd0);
		touch_slot(OP_ADDREF, 4'd15);
		touch_slot(OP_FREE, 4'd2);
		// Pack once, then again while clean.
		touch_slot(OP_COMPACT, 4'($urandom_range(0, 15)));
		touch_slot(OP_COMPACT, 4'($urandom_range(0, 15)));
		// The freed slot is reused; reserved commands are ignored.
		place_mesh(24'($urandom_range(1, 4096)), 24'($urandom_range(1, 4096)), mesh_stride);
		touch_slot(OP_FREE, 4'd1);
		issue(OP_RSVD_FIRST, 4'hF, 24'hFFFFFF, 24'hFFFFFF, 10'h3FF);
		issue(OP_RSVD_LAST, 4'h0, 24'h0, 24'h0, 10'h0);
		// Fill the table, overflow it, and pack all sixteen slots.
		repeat (NUM_SLOTS - 2)
			place_mesh(24'($urandom_range(1, 24'hFFFFFF)),
				24'($urandom_range(1, 24'hFFFFFF)), mesh_stride);
		place_mesh(24'd7, 24'd9, mesh_stride);
		place_mesh(24'd7, 24'd9, 10'd1);
		touch_slot(OP_COMPACT, 4'($urandom_range(0, 15)));
		// Empty the table and pack with nothing live.
		for (int i = 0; i < NUM_SLOTS; i++)
			touch_slot(OP_FREE, 4'(i));
		touch_slot(OP_COMPACT, 4'($urandom_range(0, 15)));

		// Back-to-back commands on one slot with no idling on either side.
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		place_mesh(24'd100, 24'd300, mesh_stride);
		repeat (BURST_ADDREFS)
			touch_slot(OP_ADDREF, 4'd0);
		touch_slot(OP_QUERY, 4'd0);
		touch_slot(OP_FREE, 4'd0);
		touch_slot(OP_COMPACT, 4'($urandom_range(0, 15)));

		// Random episodes: single commands, allocation bursts and release bursts.
		rand_start = cmds_sent;
		while (cmds_sent - rand_start < RANDOM_CMDS) begin
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			if (cmds_sent - rand_start >= 30)
				rx_hold_req = 1'b1;
			kind = $urandom_range(0, 19);
			burst = (kind >= 15) ? $urandom_range(3, 12) : 1;
			repeat (burst) begin
				if (kind < 6 || (kind >= 15 && kind < 18))
					place_mesh(mesh_count(), mesh_count(), stride_pick());
				else if (kind < 8)
					touch_slot(OP_ADDREF, 4'($urandom_range(0, 15)));
				else if (kind < 10 || kind >= 18)
					touch_slot(OP_FREE, 4'($urandom_range(0, 15)));
				else if (kind < 12)
					touch_slot(OP_QUERY, 4'($urandom_range(0, 15)));
				else if (kind < 14)
					touch_slot(OP_COMPACT, 4'($urandom_range(0, 15)));
				else
					issue(3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)),
						4'($urandom), 24'($urandom), 24'($urandom), 10'($urandom));
			end
		end
		in_valid <= 1'b0;

		// Let the last results drain, then allow for stragglers.
		@(posedge clk);
		while (pending_cnt != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands: table edge cases, back-to-back traffic, %0d random.",
			cmds_sent, cmds_sent - rand_start);
		$display("Checked %0d results; %0d mismatches, %0d results never arrived.",
			results_checked, fail_count, pending_cnt);
		if (fail_count == 0 && pending_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
